// ----- rtl/csvt_pkg.sv -----
// Shared types and constants for the CSV stream tokenizer.
// Used by the controller, the datapath and the top level. No dependencies.
`default_nettype none

package csvt_pkg;

	// Leading-whitespace buffer of a text line
	localparam int PEND_DEPTH = 16;
	localparam int PEND_AW    = (PEND_DEPTH > 1) ? $clog2(PEND_DEPTH) : 1;
	localparam int PEND_CW    = $clog2(PEND_DEPTH + 1);

	localparam logic [7:0] BYTE_BIN_MARK = 8'hFF;
	localparam logic [7:0] BYTE_COMMA    = 8'h2C;
	localparam logic [7:0] BYTE_LF       = 8'h0A;
	localparam logic [7:0] BYTE_CR       = 8'h0D;
	localparam logic [7:0] BYTE_SPACE    = 8'h20;
	localparam logic [7:0] BYTE_TAB      = 8'h09;
	localparam logic [7:0] BYTE_NUL      = 8'h00;

	localparam logic [1:0] ERR_NONE        = 2'd0;
	localparam logic [1:0] ERR_WS_OVERFLOW = 2'd1;
	localparam logic [1:0] ERR_TRUNCATED   = 2'd2;

	typedef struct packed {
		logic       byte_valid;
		logic [7:0] field_byte;
		logic       field_end;
		logic       line_end;
		logic [1:0] error_code;
	} res_t;

	// Source of the next result loaded into the output register
	typedef enum logic [1:0] {
		SEL_NEW_A,
		SEL_FLUSH,
		SEL_TAIL_A,
		SEL_TAIL_B
	} sel_t;

	typedef struct packed {
		logic accept;
		logic flush_adv;
		logic out_load;
		sel_t out_sel;
		logic out_last;
	} cmd_t;

	typedef struct packed {
		logic       out_free;
		logic       flush_req;
		logic [1:0] tail_n;
		logic       flush_last;
		logic [1:0] tail_n_q;
	} sts_t;

	function automatic res_t mk_res(input logic bv, input logic [7:0] b, input logic fe,
	                                input logic le, input logic [1:0] err);
		res_t r;
		r.byte_valid = bv;
		r.field_byte = b;
		r.field_end  = fe;
		r.line_end   = le;
		r.error_code = err;
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/csvt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module csvt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/csvt_dp.sv -----
// Datapath of the CSV stream tokenizer: mode and binary counters, whitespace
// buffer, per-request result list and output register. Depends on csvt_pkg, csvt_ram.
`default_nettype none

module csvt_dp (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic [7:0]     in_byte,
	input  wire logic           end_of_file,
	input  wire logic           out_stall,
	input  wire csvt_pkg::cmd_t cmd,
	output csvt_pkg::sts_t      sts,
	output logic                out_valid,
	output csvt_pkg::res_t      out_res,
	output logic                out_last
);
	import csvt_pkg::*;

	typedef enum logic [2:0] {
		PH_HEADER = 3'd0,
		PH_LINES  = 3'd1,
		PH_UNITS  = 3'd2,
		PH_LENGTH = 3'd3,
		PH_DATA   = 3'd4,
		PH_DONE   = 3'd5
	} phase_t;

	// File state
	logic               start_q, start_d;
	logic               bin_q, bin_d;
	logic               nonblank_q, nonblank_d;
	logic [PEND_CW-1:0] pend_cnt_q, pend_cnt_d;
	phase_t             phase_q, phase_d;
	logic [1:0]         cidx_q, cidx_d;
	logic [31:0]        shift_q, shift_d;
	logic [31:0]        lines_q, lines_d;
	logic [31:0]        units_q, units_d;
	logic [31:0]        bytes_q, bytes_d;

	// Result list of the accepted request
	logic [PEND_CW-1:0] flush_n_q;
	logic [PEND_CW-1:0] idx_q;
	logic               comma_q;
	logic [1:0]         tail_n_q;
	res_t               tail_a_q, tail_b_q;

	logic               out_valid_q;
	res_t               out_res_q;
	logic               out_last_q;

	logic               wr_en;
	logic               flush_req;
	logic               e0_v, e1_v;
	res_t               e0, e1;
	res_t               new_a;
	logic [1:0]         tail_n;
	logic [31:0]        shift_nx;
	logic               last_unit, more_lines, bin_now, text_act, bin_act;
	logic               is_nl, is_ws, is_comma;
	logic [31:0]        lines_dec;
	logic [31:0]        close_units;
	logic [31:0]        close_lines;
	phase_t             close_phase;
	logic [PEND_CW-1:0] idx_nx;
	logic [PEND_AW-1:0] raddr;
	logic [7:0]         rdata;
	logic               flush_last;
	res_t               load_res;

	csvt_ram #(
		.WIDTH(8),
		.DEPTH(PEND_DEPTH)
	) u_pend_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(pend_cnt_q[PEND_AW-1:0]),
		.wdata(in_byte),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign is_nl    = (in_byte == BYTE_LF) || (in_byte == BYTE_CR);
	assign is_ws    = (in_byte == BYTE_SPACE) || (in_byte == BYTE_TAB) || (in_byte == BYTE_NUL);
	assign is_comma = (in_byte == BYTE_COMMA);

	assign last_unit   = ~|units_q[31:1];
	assign more_lines  = |lines_q[31:1];
	assign lines_dec   = (lines_q == 32'd0) ? 32'd0 : lines_q - 32'd1;
	assign close_units = last_unit ? 32'd0 : units_q - 32'd1;
	assign close_lines = last_unit ? lines_dec : lines_q;
	assign close_phase = last_unit ? (more_lines ? PH_UNITS : PH_DONE) : PH_LENGTH;

	assign bin_now  = start_q ? (in_byte == BYTE_BIN_MARK) : bin_q;
	assign text_act = start_q ? (in_byte != BYTE_BIN_MARK) : !bin_q;
	assign bin_act  = !start_q && bin_q;

	// Merge the current byte into the count being assembled
	always_comb begin
		shift_nx = shift_q;
		case (cidx_q)
			2'd0:    shift_nx[7:0]   = shift_q[7:0] | in_byte;
			2'd1:    shift_nx[15:8]  = shift_q[15:8] | in_byte;
			2'd2:    shift_nx[23:16] = shift_q[23:16] | in_byte;
			default: shift_nx[31:24] = shift_q[31:24] | in_byte;
		endcase
	end

	// Next state and up to two trailing results of the offered byte
	always_comb begin
		start_d    = start_q;
		bin_d      = bin_q;
		nonblank_d = nonblank_q;
		pend_cnt_d = pend_cnt_q;
		phase_d    = phase_q;
		cidx_d     = cidx_q;
		shift_d    = shift_q;
		lines_d    = lines_q;
		units_d    = units_q;
		bytes_d    = bytes_q;
		wr_en      = 1'b0;
		flush_req  = 1'b0;
		e0_v       = 1'b0;
		e1_v       = 1'b0;
		e0         = mk_res(1'b0, 8'd0, 1'b0, 1'b0, ERR_NONE);
		e1         = mk_res(1'b0, 8'd0, 1'b0, 1'b0, ERR_NONE);

		if (start_q) begin
			start_d = 1'b0;
			bin_d   = (in_byte == BYTE_BIN_MARK);
			if (in_byte == BYTE_BIN_MARK) begin
				phase_d = PH_HEADER;
				cidx_d  = 2'd1;
			end
		end

		if (text_act) begin
			if (is_nl) begin
				e0_v       = nonblank_q;
				e0         = mk_res(1'b0, 8'd0, 1'b1, 1'b1, ERR_NONE);
				nonblank_d = 1'b0;
				pend_cnt_d = '0;
			end else if (!nonblank_q && is_ws) begin
				if (pend_cnt_q < PEND_CW'(PEND_DEPTH)) begin
					wr_en      = 1'b1;
					pend_cnt_d = pend_cnt_q + PEND_CW'(1);
				end else begin
					e0_v = 1'b1;
					e0   = mk_res(1'b0, 8'd0, 1'b0, 1'b0, ERR_WS_OVERFLOW);
				end
			end else begin
				flush_req  = !nonblank_q && (pend_cnt_q != '0);
				nonblank_d = 1'b1;
				pend_cnt_d = '0;
				if (is_comma) begin
					e0_v = nonblank_q || (pend_cnt_q == '0);
					e0   = mk_res(1'b0, 8'd0, 1'b1, 1'b0, ERR_NONE);
					e1_v = end_of_file;
					e1   = mk_res(1'b0, 8'd0, 1'b1, 1'b1, ERR_NONE);
				end else begin
					e0_v = 1'b1;
					e0   = mk_res(1'b1, in_byte, end_of_file, end_of_file, ERR_NONE);
				end
			end
		end

		if (bin_act) begin
			case (phase_q)
				PH_HEADER: begin
					if (cidx_q == 2'd3) begin
						cidx_d  = 2'd0;
						shift_d = 32'd0;
						phase_d = PH_LINES;
					end else begin
						cidx_d = cidx_q + 2'd1;
					end
				end
				PH_DATA: begin
					bytes_d = (bytes_q == 32'd0) ? 32'd0 : bytes_q - 32'd1;
					e0_v    = 1'b1;
					e0      = mk_res(1'b1, in_byte, 1'b0, 1'b0, ERR_NONE);
					if (~|bytes_q[31:1]) begin
						e0.field_end = 1'b1;
						e0.line_end  = last_unit;
						units_d      = close_units;
						lines_d      = close_lines;
						phase_d      = close_phase;
					end
				end
				PH_LINES, PH_UNITS, PH_LENGTH: begin
					if (cidx_q != 2'd3) begin
						shift_d = shift_nx;
						cidx_d  = cidx_q + 2'd1;
					end else begin
						cidx_d  = 2'd0;
						shift_d = 32'd0;
						case (phase_q)
							PH_LINES: begin
								lines_d = shift_nx;
								phase_d = (shift_nx != 32'd0) ? PH_UNITS : PH_DONE;
							end
							PH_UNITS: begin
								units_d = shift_nx;
								if (shift_nx == 32'd0) begin
									e0_v    = 1'b1;
									e0      = mk_res(1'b0, 8'd0, 1'b0, 1'b1, ERR_NONE);
									lines_d = lines_dec;
									phase_d = more_lines ? PH_UNITS : PH_DONE;
								end else begin
									phase_d = PH_LENGTH;
								end
							end
							default: begin
								bytes_d = shift_nx;
								if (shift_nx == 32'd0) begin
									e0_v    = 1'b1;
									e0      = mk_res(1'b0, 8'd0, 1'b1, last_unit, ERR_NONE);
									units_d = close_units;
									lines_d = close_lines;
									phase_d = close_phase;
								end else begin
									phase_d = PH_DATA;
								end
							end
						endcase
					end
				end
				default: begin
				end
			endcase
		end

		// End of file: flag an unfinished binary file, then start over
		if (end_of_file) begin
			if (bin_now && (phase_d != PH_DONE)) begin
				e1_v = 1'b1;
				e1   = mk_res(1'b0, 8'd0, 1'b0, 1'b0, ERR_TRUNCATED);
			end
			start_d    = 1'b1;
			bin_d      = 1'b0;
			nonblank_d = 1'b0;
			pend_cnt_d = '0;
			phase_d    = PH_HEADER;
			cidx_d     = 2'd0;
			shift_d    = 32'd0;
			lines_d    = 32'd0;
			units_d    = 32'd0;
			bytes_d    = 32'd0;
		end
	end

	// Pack the trailing results to the front of the list
	assign new_a  = e0_v ? e0 : e1;
	assign tail_n = {1'b0, e0_v} + {1'b0, e1_v};

	assign flush_last = ((idx_q + PEND_CW'(1)) == flush_n_q);
	assign idx_nx     = cmd.accept ? '0 : (cmd.flush_adv ? idx_q + PEND_CW'(1) : idx_q);
	assign raddr      = idx_nx[PEND_AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q    <= 1'b1;
			bin_q      <= 1'b0;
			nonblank_q <= 1'b0;
			pend_cnt_q <= '0;
			phase_q    <= PH_HEADER;
			cidx_q     <= 2'd0;
			shift_q    <= 32'd0;
			lines_q    <= 32'd0;
			units_q    <= 32'd0;
			bytes_q    <= 32'd0;
			tail_n_q   <= 2'd0;
			flush_n_q  <= '0;
			idx_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				start_q    <= start_d;
				bin_q      <= bin_d;
				nonblank_q <= nonblank_d;
				pend_cnt_q <= pend_cnt_d;
				phase_q    <= phase_d;
				cidx_q     <= cidx_d;
				shift_q    <= shift_d;
				lines_q    <= lines_d;
				units_q    <= units_d;
				bytes_q    <= bytes_d;
				tail_n_q   <= tail_n;
				flush_n_q  <= pend_cnt_q;
			end
			idx_q <= idx_nx;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		case (cmd.out_sel)
			SEL_NEW_A:  load_res = new_a;
			SEL_FLUSH:  load_res = mk_res(1'b1, rdata, comma_q && flush_last, 1'b0, ERR_NONE);
			SEL_TAIL_A: load_res = tail_a_q;
			SEL_TAIL_B: load_res = tail_b_q;
			default:    load_res = tail_b_q;
		endcase
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			comma_q  <= is_comma;
			tail_a_q <= new_a;
			tail_b_q <= e1;
		end
		if (cmd.out_load) begin
			out_res_q  <= load_res;
			out_last_q <= cmd.out_last;
		end
	end

	assign sts.out_free   = !out_valid_q || !out_stall;
	assign sts.flush_req  = flush_req;
	assign sts.tail_n     = tail_n;
	assign sts.flush_last = flush_last;
	assign sts.tail_n_q   = tail_n_q;

	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;
	assign out_last  = out_last_q;

endmodule

`default_nettype wire

// ----- rtl/csvt_ctrl.sv -----
// Controller of the CSV stream tokenizer: sequences held-whitespace flush and
// trailing results of each request. Depends on csvt_pkg.
`default_nettype none

module csvt_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire csvt_pkg::sts_t sts,
	output csvt_pkg::cmd_t      cmd
);
	import csvt_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FLUSH,
		ST_TAIL0,
		ST_TAIL1
	} state_t;

	state_t state_q, state_d;

	assign in_stall = !((state_q == ST_IDLE) && sts.out_free);

	always_comb begin
		state_d       = state_q;
		cmd.accept    = 1'b0;
		cmd.flush_adv = 1'b0;
		cmd.out_load  = 1'b0;
		cmd.out_sel   = SEL_NEW_A;
		cmd.out_last  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && sts.out_free) begin
					cmd.accept = 1'b1;
					if (sts.flush_req) begin
						state_d = ST_FLUSH;
					end else if (sts.tail_n != 2'd0) begin
						// first result goes straight to the output register
						cmd.out_load = 1'b1;
						cmd.out_last = (sts.tail_n == 2'd1);
						state_d      = (sts.tail_n == 2'd2) ? ST_TAIL1 : ST_IDLE;
					end
				end
			end
			ST_FLUSH: begin
				if (sts.out_free) begin
					cmd.out_load  = 1'b1;
					cmd.out_sel   = SEL_FLUSH;
					cmd.flush_adv = 1'b1;
					cmd.out_last  = sts.flush_last && (sts.tail_n_q == 2'd0);
					if (sts.flush_last) begin
						state_d = (sts.tail_n_q != 2'd0) ? ST_TAIL0 : ST_IDLE;
					end
				end
			end
			ST_TAIL0: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = SEL_TAIL_A;
					cmd.out_last = (sts.tail_n_q == 2'd1);
					state_d      = (sts.tail_n_q == 2'd2) ? ST_TAIL1 : ST_IDLE;
				end
			end
			ST_TAIL1: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = SEL_TAIL_B;
					cmd.out_last = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/csv_stream_tokenizer.sv -----
// Top level of the CSV stream tokenizer: joins controller and datapath.
// Depends on csvt_pkg, csvt_ctrl, csvt_dp.
`default_nettype none

// Takes a file one byte per request, end_of_file set on its last byte, and
// returns field bytes and markers with field_end, line_end and error flags;
// last_of_run marks the final result of each input byte. A leading 0xFF selects
// the length-prefixed binary form, anything else is CSV text in which blank
// lines are dropped. A byte giving at most one result is taken one per cycle
// while the output is free; one giving two stalls the input for its second, and
// one proving a text line non-blank after held whitespace stalls it while the
// buffer is read one entry per free output cycle and its trailing results load.
// The buffer holds PEND_DEPTH bytes and needs no clearing after reset; a further
// whitespace byte is dropped with an overflow error result. Results sit in a
// single output register; a byte is taken only while that register is empty or
// its result leaves in the same cycle, so a stalled result holds off the input.

module csv_stream_tokenizer (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] in_byte,
	input  wire logic       end_of_file,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            byte_valid,
	output logic [7:0]      field_byte,
	output logic            field_end,
	output logic            line_end,
	output logic [1:0]      error_code,
	output logic            last_of_run
);
	import csvt_pkg::*;

	cmd_t cmd;
	sts_t sts;
	res_t out_res;

	csvt_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	csvt_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_byte    (in_byte),
		.end_of_file(end_of_file),
		.out_stall  (out_stall),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (out_valid),
		.out_res    (out_res),
		.out_last   (last_of_run)
	);

	assign byte_valid = out_res.byte_valid;
	assign field_byte = out_res.field_byte;
	assign field_end  = out_res.field_end;
	assign line_end   = out_res.line_end;
	assign error_code = out_res.error_code;

endmodule

`default_nettype wire
